[hdl/srct_pkg.sv]
`timescale 1ns / 1ps
package srct_pkg;

   localparam logic [2:0] MODE_INSERT     = 3'd0;
   localparam logic [2:0] MODE_DIRECT     = 3'd1;
   localparam logic [2:0] MODE_CHAIN_TEST = 3'd2;
   localparam logic [2:0] MODE_SUCC       = 3'd3;
   localparam logic [2:0] MODE_PRED       = 3'd4;
   localparam logic [2:0] MODE_SUCC_CHAIN = 3'd5;
   localparam logic [2:0] MODE_PRED_CHAIN = 3'd6;

   localparam logic [1:0] ST_TRUE  = 2'd0;
   localparam logic [1:0] ST_FALSE = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_CUT   = 2'd3;

   localparam int NODE_W = 6;

   // controller -> datapath
   typedef struct packed {
      logic       load;      // capture request, start cursor at first node
      logic       row_rd;    // read row at cursor
      logic       set_bit;   // write inserted pair
      logic       advance;   // cursor <= found node, step++
      logic       col_clr;   // clear predecessor search
      logic       col_step;  // examine one row for the predecessor column
      logic       out_load;  // load output register
      logic [NODE_W-1:0] out_node;
      logic [1:0] out_status;
      logic       out_last;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic              hit;             // bit at (cursor row, second) set
      logic              found;           // lowest link exists
      logic [NODE_W-1:0] found_node;
      logic              succ_is_second;  // lowest successor is the second node
   } dp_stat_type;

endpackage

[hdl/srct_ram.sv]
`timescale 1ns / 1ps
module srct_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

[hdl/srct_datapath.sv]
`timescale 1ns / 1ps
module srct_datapath
   import srct_pkg::*;
#(
   parameter int NODES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  ctl_cmd_type       cmd,
   input  logic              clr_en,
   input  logic [NODE_W-1:0] clr_addr,
   input  logic [NODE_W-1:0] req_first,
   input  logic [NODE_W-1:0] req_second,
   input  logic              pred_mode,
   output dp_stat_type       stat,
   output logic [NODE_W-1:0] rsp_node,
   output logic [1:0]        rsp_status,
   output logic              rsp_last
);
   localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

   logic [NODE_W-1:0] cursor_ff, cursor_in;
   logic [NODE_W-1:0] second_ff;
   logic [NODE_W-1:0] sweep_ff, sweep_in;
   logic              pfound_ff, pfound_in;
   logic [NODE_W-1:0] pnode_ff, pnode_in;
   logic              sweep_vld_ff;
   logic [NODE_W-1:0] sweep_row_ff;
   logic [63:0]       row_q;
   logic [63:0]       row_m;
   logic              s_found;
   logic [NODE_W-1:0] s_node;
   logic [AW-1:0]     rd_addr;
   logic [63:0]       wr_data;

   // sweep address feeds the RAM while searching a column
   assign rd_addr = cmd.col_step ? sweep_ff[AW-1:0] : cursor_in[AW-1:0];

   always_comb begin
      wr_data = clr_en ? 64'd0 : (row_q | (64'd1 << second_ff));
   end

   srct_ram #(.WIDTH(64), .DEPTH(NODES)) u_ram (
      .clock  (clock),
      .wr_en  (clr_en | cmd.set_bit),
      .wr_addr(clr_en ? clr_addr[AW-1:0] : cursor_ff[AW-1:0]),
      .wr_data(wr_data),
      .rd_en  (cmd.row_rd | cmd.col_step),
      .rd_addr(rd_addr),
      .rd_data(row_q)
   );

   always_comb begin
      row_m = row_q;
      if (NODES < 64) begin
         row_m = row_q & ((64'd1 << NODES) - 64'd1);
      end
      s_found = 1'b0;
      s_node  = '0;
      for (int i = 63; i >= 0; i--) begin
         if (row_m[i]) begin
            s_found = 1'b1;
            s_node  = NODE_W'(i);
         end
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      if (cmd.load) begin
         cursor_in = req_first;
      end else if (cmd.advance) begin
         cursor_in = pred_mode ? pnode_ff : s_node;
      end
      sweep_in  = sweep_ff;
      pfound_in = pfound_ff;
      pnode_in  = pnode_ff;
      if (cmd.col_clr) begin
         sweep_in  = '0;
         pfound_in = 1'b0;
         pnode_in  = '0;
      end else begin
         if (cmd.col_step) begin
            sweep_in = sweep_ff + 1'b1;
         end
         if (sweep_vld_ff && !pfound_ff && row_q[cursor_ff]) begin
            pfound_in = 1'b1;
            pnode_in  = sweep_row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_vld_ff <= 1'b0;
      end else begin
         sweep_vld_ff <= cmd.col_step;
      end
      cursor_ff    <= cursor_in;
      sweep_ff     <= sweep_in;
      sweep_row_ff <= sweep_ff;
      pfound_ff    <= pfound_in;
      pnode_ff     <= pnode_in;
      if (cmd.load) begin
         second_ff <= req_second;
      end
      if (cmd.out_load) begin
         rsp_node   <= cmd.out_node;
         rsp_status <= cmd.out_status;
         rsp_last   <= cmd.out_last;
      end
   end

   assign stat.hit            = row_q[second_ff];
   assign stat.found          = pred_mode ? pfound_ff : s_found;
   assign stat.found_node     = pred_mode ? pnode_ff : s_node;
   assign stat.succ_is_second = (s_node == second_ff);
endmodule

[hdl/srct_control.sv]
`timescale 1ns / 1ps
module srct_control
   import srct_pkg::*;
#(
   parameter int NODES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [2:0]        req_mode,
   input  logic [NODE_W-1:0] req_first,
   input  logic [NODE_W-1:0] req_second,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  dp_stat_type       stat,
   output ctl_cmd_type       cmd,
   output logic              clr_en,
   output logic [NODE_W-1:0] clr_addr,
   output logic              pred_mode
);
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_COL   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [2:0]        mode_ff, mode_in;
   logic [6:0]        step_ff, step_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic              vld_ff, vld_in;
   logic [NODE_W-1:0] pend_node_ff, pend_node_in;
   logic              pend_ff, pend_in;
   logic [6:0]        sweep_cnt_ff, sweep_cnt_in;
   logic              a_ok, b_ok, is_walk, is_pred;

   assign a_ok       = 7'(req_first) < 7'(NODES);
   assign b_ok       = 7'(req_second) < 7'(NODES);
   assign is_walk    = (mode_ff == MODE_CHAIN_TEST) || (mode_ff == MODE_SUCC_CHAIN) ||
                       (mode_ff == MODE_PRED_CHAIN);
   assign is_pred    = (mode_ff == MODE_PRED) || (mode_ff == MODE_PRED_CHAIN);
   assign pred_mode  = is_pred;
   assign clr_en     = (state_ff == S_CLEAR);
   assign clr_addr   = clr_ff;
   assign rsp_tvalid = vld_ff;
   assign req_tready = (state_ff == S_IDLE) && !vld_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      vld_in       = vld_ff;
      pend_node_in = pend_node_ff;
      pend_in      = pend_ff;
      sweep_cnt_in = sweep_cnt_ff;
      cmd          = '0;
      if (vld_ff && rsp_tready) begin
         vld_in = 1'b0;
      end
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (7'(clr_ff) == 7'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               mode_in  = req_mode;
               step_in  = '0;
               pend_in  = 1'b0;
               cmd.load = 1'b1;
               cmd.out_node = '0;
               cmd.out_last = 1'b1;
               if (req_mode == MODE_INSERT || req_mode == MODE_DIRECT ||
                   req_mode == MODE_CHAIN_TEST) begin
                  if (!a_ok || !b_ok) begin
                     cmd.out_load = 1'b1; cmd.out_status = ST_RANGE; vld_in = 1'b1;
                  end else if (req_mode == MODE_CHAIN_TEST &&
                               (req_first == '0 || req_second == '0)) begin
                     cmd.out_load = 1'b1; cmd.out_status = ST_FALSE; vld_in = 1'b1;
                  end else begin
                     cmd.row_rd = 1'b1; state_in = S_READ;
                  end
               end else if (req_mode == MODE_SUCC || req_mode == MODE_PRED ||
                            req_mode == MODE_SUCC_CHAIN || req_mode == MODE_PRED_CHAIN) begin
                  if (!a_ok) begin
                     cmd.out_load = 1'b1; cmd.out_status = ST_RANGE; vld_in = 1'b1;
                  end else begin
                     cmd.row_rd = 1'b1; state_in = S_READ;
                  end
               end else begin
                  cmd.out_load = 1'b1; cmd.out_status = ST_RANGE; vld_in = 1'b1;
               end
            end
         end
         S_READ: begin
            if (is_pred) begin
               cmd.col_clr  = 1'b1;
               sweep_cnt_in = '0;
               state_in     = S_COL;
            end else begin
               state_in = S_EVAL;
            end
         end
         S_COL: begin
            if (sweep_cnt_ff < 7'(NODES)) begin
               cmd.col_step = 1'b1;
               sweep_cnt_in = sweep_cnt_ff + 1'b1;
            end else if (sweep_cnt_ff == 7'(NODES)) begin
               sweep_cnt_in = sweep_cnt_ff + 1'b1;  // drain last read
            end else begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.out_node = '0;
            cmd.out_last = 1'b1;
            unique case (mode_ff) inside
               MODE_INSERT: begin
                  if (!vld_in) begin
                     cmd.out_load = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
                     if (stat.hit) begin
                        cmd.out_status = ST_FALSE;
                     end else begin
                        cmd.set_bit    = 1'b1;
                        cmd.out_status = ST_TRUE;
                        cmd.out_node   = NODE_W'(NODES - 1);
                     end
                  end
               end
               MODE_DIRECT: begin
                  if (!vld_in) begin
                     cmd.out_load = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
                     cmd.out_status = stat.hit ? ST_TRUE : ST_FALSE;
                  end
               end
               MODE_SUCC, MODE_PRED: begin
                  if (!vld_in) begin
                     cmd.out_load = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
                     cmd.out_status = stat.found ? ST_TRUE : ST_FALSE;
                     cmd.out_node   = stat.found ? stat.found_node : '0;
                  end
               end
               MODE_CHAIN_TEST: begin
                  if (!stat.found) begin
                     if (!vld_in) begin
                        cmd.out_load = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
                        cmd.out_status = ST_FALSE;
                     end
                  end else if (stat.succ_is_second) begin
                     if (!vld_in) begin
                        cmd.out_load = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
                        cmd.out_status = ST_TRUE;
                     end
                  end else if (step_ff + 1'b1 >= 7'(NODES)) begin
                     if (!vld_in) begin
                        cmd.out_load = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
                        cmd.out_status = ST_CUT;
                     end
                  end else begin
                     cmd.advance = 1'b1; cmd.row_rd = 1'b1;
                     step_in = step_ff + 1'b1; state_in = S_READ;
                  end
               end
               default: begin
                  // chain emission; one result is held back to tag the last
                  if (!stat.found) begin
                     if (!vld_in) begin
                        cmd.out_load = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
                        cmd.out_status = pend_ff ? ST_TRUE : ST_FALSE;
                        cmd.out_node   = pend_ff ? pend_node_ff : '0;
                     end
                  end else if (step_ff >= 7'(NODES)) begin
                     if (!vld_in) begin
                        cmd.out_load = 1'b1; vld_in = 1'b1; state_in = S_IDLE;
                        cmd.out_status = ST_CUT;
                        cmd.out_node   = pend_node_ff;
                     end
                  end else if (!pend_ff || !vld_in) begin
                     if (pend_ff) begin
                        cmd.out_load = 1'b1; vld_in = 1'b1;
                        cmd.out_status = ST_TRUE;
                        cmd.out_node   = pend_node_ff;
                        cmd.out_last   = 1'b0;
                     end
                     pend_in      = 1'b1;
                     pend_node_in = stat.found_node;
                     cmd.advance  = 1'b1; cmd.row_rd = 1'b1;
                     step_in = step_ff + 1'b1; state_in = S_READ;
                  end
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         vld_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         vld_ff   <= vld_in;
         pend_ff  <= pend_in;
         step_ff  <= step_in;
      end
      mode_ff      <= mode_in;
      pend_node_ff <= pend_node_in;
      sweep_cnt_ff <= sweep_cnt_in;
   end
endmodule

[hdl/successor_relation_chain_table_core.sv]
`timescale 1ns / 1ps
// Relation table over NODES nodes with chain walks.
// req_ channel: one request per transfer; tdata = {second_node, first_node, mode}.
// rsp_ channel: result items; tdata = {status, node_value}, tlast = last result of
//   the request. Every mode gives one result except the successor and predecessor
//   chain modes, which give one per chain element (at most NODES).
// Range errors are answered from the idle state without a matrix read. Insert, the
//   direct test and successor lookups read one matrix row; the chain test and
//   successor chains read one row per link, while predecessor lookups sweep all
//   rows of the matrix for each link.
// One request is worked on at a time; req_tready is low while it runs or while
//   a result waits. If the receiver stalls, the walk pauses on the held result.
// Reset: synchronous, active high; the matrix is then cleared one row per cycle
//   until all NODES rows are clear, and no request is accepted before that.
module successor_relation_chain_table_core
   import srct_pkg::*;
#(
   parameter int NODES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [2:0] mode, [8:3] first_node, [14:9] second_node
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [5:0] node_value, [7:6] status
   output logic        rsp_tlast
);
   ctl_cmd_type       cmd;
   dp_stat_type       stat;
   logic              clr_en, pred_mode;
   logic [NODE_W-1:0] clr_addr, node_q;
   logic [1:0]        status_q;

   srct_control #(.NODES(NODES)) u_ctl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_mode(req_tdata[2:0]), .req_first(req_tdata[8:3]), .req_second(req_tdata[14:9]),
      .rsp_tvalid, .rsp_tready, .stat, .cmd, .clr_en, .clr_addr, .pred_mode
   );

   srct_datapath #(.NODES(NODES)) u_dp (
      .clock, .reset, .cmd, .clr_en, .clr_addr,
      .req_first(req_tdata[8:3]), .req_second(req_tdata[14:9]), .pred_mode, .stat,
      .rsp_node(node_q), .rsp_status(status_q), .rsp_last(rsp_tlast)
   );

   assign rsp_tdata = {status_q, node_q};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
endmodule
